/* hdl/lups_pkg.sv */
// shared constants, types and saturating arithmetic for the lu solver
package lups_pkg;

   localparam int MAX_SIZE   = 16;
   localparam int IDX_BITS   = 4;
   localparam int CNT_BITS   = 5;
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int VALUE_BITS = 48;
   localparam int FRAC_BITS  = 24;
   localparam int HALF_BITS  = VALUE_BITS / 2;
   localparam int PROD_BITS  = 2 * VALUE_BITS;
   localparam int QUOT_BITS  = VALUE_BITS + FRAC_BITS;
   localparam int QCNT_BITS  = 7;

   localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
   localparam logic [1:0] CMD_SOLVE       = 2'd2;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [VALUE_BITS-1:0]        mag_type;
   typedef logic [QUOT_BITS:0]           wide_type;

   localparam value_type MAX_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type MIN_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // request and response of a shared arithmetic unit
   typedef struct packed {
      logic      start;
      value_type a;
      value_type b;
   } op_req_type;

   typedef struct packed {
      logic      done;
      value_type value;
   } op_rsp_type;

   function automatic mag_type magnitude(value_type x);
      return x[VALUE_BITS-1] ? mag_type'(-x) : mag_type'(x);
   endfunction

   // sign and magnitude back to a saturated value
   function automatic value_type sat_mag(logic neg, wide_type mag);
      wide_type lim;
      lim = wide_type'(1) << (VALUE_BITS - 1);
      if (neg) begin
         if (mag >= lim) return MIN_VALUE;
         return value_type'(mag_type'(0) - mag[VALUE_BITS-1:0]);
      end
      if (mag >= lim) return MAX_VALUE;
      return value_type'(mag[VALUE_BITS-1:0]);
   endfunction

   function automatic value_type sat_add(value_type a, value_type b);
      logic signed [VALUE_BITS:0] s;
      s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
      if (s[VALUE_BITS] != s[VALUE_BITS-1])
         return s[VALUE_BITS] ? MIN_VALUE : MAX_VALUE;
      return value_type'(s[VALUE_BITS-1:0]);
   endfunction

   function automatic value_type sat_sub(value_type a, value_type b);
      logic signed [VALUE_BITS:0] s;
      s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
      if (s[VALUE_BITS] != s[VALUE_BITS-1])
         return s[VALUE_BITS] ? MIN_VALUE : MAX_VALUE;
      return value_type'(s[VALUE_BITS-1:0]);
   endfunction

endpackage

/* hdl/lups_ram.sv */
// generic single write port ram with registered read
module lups_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hdl/lups_mul.sv */
// fixed point multiplier: four half-width partial products, round and saturate
module lups_mul (
   input  logic                clock,
   input  logic                reset,
   input  lups_pkg::op_req_type req,
   output lups_pkg::op_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic [2:0]                          step_ff, step_in;
   lups_pkg::mag_type                   ma_ff, ma_in, mb_ff, mb_in;
   logic                                neg_ff, neg_in;
   logic [lups_pkg::PROD_BITS-1:0]      acc_ff, acc_in;
   lups_pkg::op_rsp_type                rsp_ff, rsp_in;
   logic [lups_pkg::HALF_BITS-1:0]      ah, bh;
   logic [lups_pkg::VALUE_BITS-1:0]     pp;
   logic [lups_pkg::PROD_BITS-1:0]      term, rounded;

   // partial product of the current step
   always_comb begin
      ah = step_ff[1] ? ma_ff[lups_pkg::VALUE_BITS-1:lups_pkg::HALF_BITS]
                      : ma_ff[lups_pkg::HALF_BITS-1:0];
      bh = step_ff[0] ? mb_ff[lups_pkg::VALUE_BITS-1:lups_pkg::HALF_BITS]
                      : mb_ff[lups_pkg::HALF_BITS-1:0];
      pp = ah * bh;
      unique case (step_ff[1:0])
         2'd0: term = lups_pkg::PROD_BITS'(pp);
         2'd3: term = lups_pkg::PROD_BITS'(pp) << (2 * lups_pkg::HALF_BITS);
         default: term = lups_pkg::PROD_BITS'(pp) << lups_pkg::HALF_BITS;
      endcase
      rounded = acc_ff + (lups_pkg::PROD_BITS'(1) << (lups_pkg::FRAC_BITS - 1));
   end

   // step sequence
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      rsp_in.done = 1'b0;
      rsp_in.value = rsp_ff.value;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         ma_in = lups_pkg::magnitude(req.a);
         mb_in = lups_pkg::magnitude(req.b);
         neg_in = req.a[lups_pkg::VALUE_BITS-1] ^ req.b[lups_pkg::VALUE_BITS-1];
         acc_in = '0;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            busy_in = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.value = lups_pkg::sat_mag(neg_ff,
               {1'b0, rounded[lups_pkg::PROD_BITS-1:lups_pkg::FRAC_BITS]});
         end else begin
            acc_in = acc_ff + term;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_ff.done <= rsp_in.done;
      end
      step_ff <= step_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule

/* hdl/lups_div.sv */
// fixed point divider: restoring division one quotient bit a cycle, round and saturate
module lups_div (
   input  logic                clock,
   input  logic                reset,
   input  lups_pkg::op_req_type req,
   output lups_pkg::op_rsp_type rsp
);

   logic                               busy_ff, busy_in;
   logic [lups_pkg::QCNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [lups_pkg::QUOT_BITS-1:0]     num_ff, num_in, q_ff, q_in;
   lups_pkg::mag_type                  rem_ff, rem_in, d_ff, d_in;
   logic                               neg_ff, neg_in;
   lups_pkg::op_rsp_type               rsp_ff, rsp_in;
   logic [lups_pkg::VALUE_BITS:0]      rs, rem2;
   logic                               ge, up;
   lups_pkg::wide_type                 qr;

   // one division step and the final rounding
   always_comb begin
      rs = {rem_ff, num_ff[lups_pkg::QUOT_BITS-1]};
      ge = rs >= {1'b0, d_ff};
      rem2 = {rem_ff, 1'b0};
      up = rem2 >= {1'b0, d_ff};
      qr = {1'b0, q_ff} + lups_pkg::wide_type'(up);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      rsp_in.done = 1'b0;
      rsp_in.value = rsp_ff.value;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         num_in = {lups_pkg::magnitude(req.a), {lups_pkg::FRAC_BITS{1'b0}}};
         q_in = '0;
         rem_in = '0;
         d_in = lups_pkg::magnitude(req.b);
         neg_in = req.a[lups_pkg::VALUE_BITS-1] ^ req.b[lups_pkg::VALUE_BITS-1];
      end else if (busy_ff) begin
         if (cnt_ff == lups_pkg::QCNT_BITS'(lups_pkg::QUOT_BITS)) begin
            busy_in = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.value = lups_pkg::sat_mag(neg_ff, qr);
         end else begin
            rem_in = ge ? lups_pkg::mag_type'(rs - {1'b0, d_ff})
                        : rs[lups_pkg::VALUE_BITS-1:0];
            q_in = {q_ff[lups_pkg::QUOT_BITS-2:0], ge};
            num_in = {num_ff[lups_pkg::QUOT_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_ff.done <= rsp_in.done;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp = rsp_ff;

endmodule

/* hdl/lu_pivot_linear_solver_core.sv */
// top level: lu solver with partial pivoting, sequencer around four memories
//
// Usage: the request channel takes an item when start is high and busy is low.
// Command load matrix entry writes one matrix entry, load rhs entry writes one
// right-hand-side entry; each load keeps busy low. A solve
// command raises busy, copies the active n x n matrix into a work memory,
// factors it with row pivoting (rows are swapped through an order table),
// runs forward and back substitution and streams n results on the rsp_ ports,
// rsp_valid high one cycle each, the last one marked.
// Busy falls after the last result. The receiver cannot stall the outputs.
// The multiplications of the shared multiplier and the n(n-1)/2 + n divisions
// of the bit-serial divider set the solve time.
// The user writes csr_system_size only while idle; the block does not enforce
// it. 0 acts as 1, above 16 as 16. Reset (synchronous) returns to idle with
// size 16; matrix and rhs contents are kept only as written.
module lu_pivot_linear_solver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic [lups_pkg::IDX_BITS-1:0]       req_row_index,
   input  logic [lups_pkg::IDX_BITS-1:0]       req_column_index,
   input  logic signed [lups_pkg::VALUE_BITS-1:0] req_entry_value,
   output logic                                rsp_valid,
   output logic [lups_pkg::IDX_BITS-1:0]       rsp_solution_index,
   output logic signed [lups_pkg::VALUE_BITS-1:0] rsp_solution_value,
   output logic                                rsp_last_element,
   output logic                                rsp_singular,
   input  logic                                csr_write_enable,
   input  logic [lups_pkg::CNT_BITS-1:0]       csr_system_size
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_CP_RD  = 5'd1;
   localparam logic [4:0] ST_CP_WR  = 5'd2;
   localparam logic [4:0] ST_PV_RD  = 5'd3;
   localparam logic [4:0] ST_PV_CMP = 5'd4;
   localparam logic [4:0] ST_SW_A   = 5'd5;
   localparam logic [4:0] ST_SW_B   = 5'd6;
   localparam logic [4:0] ST_EL_RD  = 5'd7;
   localparam logic [4:0] ST_EL_DIV = 5'd8;
   localparam logic [4:0] ST_EL_DW  = 5'd9;
   localparam logic [4:0] ST_EU_RB  = 5'd10;
   localparam logic [4:0] ST_EU_RC  = 5'd11;
   localparam logic [4:0] ST_EU_MW  = 5'd12;
   localparam logic [4:0] ST_FW_ST  = 5'd13;
   localparam logic [4:0] ST_FW_RD  = 5'd14;
   localparam logic [4:0] ST_FW_MS  = 5'd15;
   localparam logic [4:0] ST_FW_MW  = 5'd16;
   localparam logic [4:0] ST_FW_RHS = 5'd17;
   localparam logic [4:0] ST_FW_WR  = 5'd18;
   localparam logic [4:0] ST_BK_ST  = 5'd19;
   localparam logic [4:0] ST_BK_RD  = 5'd20;
   localparam logic [4:0] ST_BK_MS  = 5'd21;
   localparam logic [4:0] ST_BK_MW  = 5'd22;
   localparam logic [4:0] ST_BK_RW  = 5'd23;
   localparam logic [4:0] ST_BK_DS  = 5'd24;
   localparam logic [4:0] ST_BK_DW  = 5'd25;
   localparam logic [4:0] ST_OUT_RD = 5'd26;
   localparam logic [4:0] ST_OUT_EM = 5'd27;

   localparam int IB = lups_pkg::IDX_BITS;
   localparam int CB = lups_pkg::CNT_BITS;
   localparam int AB = lups_pkg::ADDR_BITS;

   logic [4:0]                 state_ff, state_in;
   logic [CB-1:0]              ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic [CB-1:0]              n_ff, n_in, size_ff, n_m1;
   logic                       sing_ff, sing_in;
   lups_pkg::mag_type          best_ff, best_in, cand;
   logic [CB-1:0]              piv_k_ff, piv_k_in;
   logic [IB-1:0]              piv_row_ff, piv_row_in, cur_row_ff, cur_row_in;
   logic [IB-1:0]              krow_ff, krow_in, jrow_ff, jrow_in;
   lups_pkg::value_type        piv_val_ff, piv_val_in, f_ff, f_in, acc_ff, acc_in;
   logic [IB-1:0]              perm_ff [lups_pkg::MAX_SIZE];
   logic [IB-1:0]              perm_addr, perm_rd, perm_wa, perm_wd;
   logic                       perm_we, perm_init;

   // memory ports
   logic                       mat_we, rhs_we, lu_we, wv_we;
   logic [AB-1:0]              mat_wa, mat_ra, lu_wa, lu_ra;
   logic [IB-1:0]              rhs_wa, rhs_ra, wv_wa, wv_ra;
   lups_pkg::value_type        lu_wd, wv_wd;
   logic [lups_pkg::VALUE_BITS-1:0] mat_rdata, rhs_rdata, lu_rdata, wv_rdata;

   lups_pkg::op_req_type       mul_req, div_req;
   lups_pkg::op_rsp_type       mul_rsp, div_rsp;

   logic                       accept;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign n_m1 = n_ff - 1'b1;
   assign perm_rd = perm_ff[perm_addr];
   assign cand = lups_pkg::magnitude(lu_rdata);

   // stored matrix, right-hand side, work matrix and work vector
   lups_ram #(.WIDTH(lups_pkg::VALUE_BITS), .DEPTH(lups_pkg::MAX_SIZE * lups_pkg::MAX_SIZE))
   u_mat_ram (.clock(clock), .we(mat_we), .waddr(mat_wa), .wdata(req_entry_value),
              .raddr(mat_ra), .rdata(mat_rdata));

   lups_ram #(.WIDTH(lups_pkg::VALUE_BITS), .DEPTH(lups_pkg::MAX_SIZE))
   u_rhs_ram (.clock(clock), .we(rhs_we), .waddr(rhs_wa), .wdata(req_entry_value),
              .raddr(rhs_ra), .rdata(rhs_rdata));

   lups_ram #(.WIDTH(lups_pkg::VALUE_BITS), .DEPTH(lups_pkg::MAX_SIZE * lups_pkg::MAX_SIZE))
   u_lu_ram (.clock(clock), .we(lu_we), .waddr(lu_wa), .wdata(lu_wd),
             .raddr(lu_ra), .rdata(lu_rdata));

   lups_ram #(.WIDTH(lups_pkg::VALUE_BITS), .DEPTH(lups_pkg::MAX_SIZE))
   u_wv_ram (.clock(clock), .we(wv_we), .waddr(wv_wa), .wdata(wv_wd),
             .raddr(wv_ra), .rdata(wv_rdata));

   // shared arithmetic units
   lups_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   lups_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // sequencer
   always_comb begin
      state_in = state_ff;
      ci_in = ci_ff;
      cj_in = cj_ff;
      ck_in = ck_ff;
      n_in = n_ff;
      sing_in = sing_ff;
      best_in = best_ff;
      piv_k_in = piv_k_ff;
      piv_row_in = piv_row_ff;
      cur_row_in = cur_row_ff;
      krow_in = krow_ff;
      jrow_in = jrow_ff;
      piv_val_in = piv_val_ff;
      f_in = f_ff;
      acc_in = acc_ff;
      perm_addr = ci_ff[IB-1:0];
      perm_we = 1'b0;
      perm_wa = ci_ff[IB-1:0];
      perm_wd = piv_row_ff;
      perm_init = 1'b0;
      mat_we = 1'b0;
      mat_wa = {req_row_index, req_column_index};
      mat_ra = {ci_ff[IB-1:0], cj_ff[IB-1:0]};
      rhs_we = 1'b0;
      rhs_wa = req_row_index;
      rhs_ra = perm_rd;
      lu_we = 1'b0;
      lu_wa = {ci_ff[IB-1:0], cj_ff[IB-1:0]};
      lu_wd = mat_rdata;
      lu_ra = {perm_rd, ci_ff[IB-1:0]};
      wv_we = 1'b0;
      wv_wa = ci_ff[IB-1:0];
      wv_wd = lups_pkg::sat_sub(rhs_rdata, acc_ff);
      wv_ra = cj_ff[IB-1:0];
      mul_req.start = 1'b0;
      mul_req.a = lu_rdata;
      mul_req.b = wv_rdata;
      div_req.start = 1'b0;
      div_req.a = lu_rdata;
      div_req.b = piv_val_ff;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  lups_pkg::CMD_LOAD_MATRIX: mat_we = 1'b1;
                  lups_pkg::CMD_LOAD_RHS: rhs_we = 1'b1;
                  lups_pkg::CMD_SOLVE: begin
                     perm_init = 1'b1;
                     ci_in = '0;
                     cj_in = '0;
                     sing_in = 1'b0;
                     if (size_ff == '0) n_in = CB'(1);
                     else if (size_ff > CB'(lups_pkg::MAX_SIZE)) n_in = CB'(lups_pkg::MAX_SIZE);
                     else n_in = size_ff;
                     state_in = ST_CP_RD;
                  end
                  default: ;
               endcase
            end
         end
         // copy the active matrix into the work memory
         ST_CP_RD: state_in = ST_CP_WR;
         ST_CP_WR: begin
            lu_we = 1'b1;
            if (cj_ff == n_m1) begin
               cj_in = '0;
               if (ci_ff == n_m1) begin
                  ci_in = '0;
                  ck_in = '0;
                  state_in = ST_PV_RD;
               end else begin
                  ci_in = ci_ff + 1'b1;
                  state_in = ST_CP_RD;
               end
            end else begin
               cj_in = cj_ff + 1'b1;
               state_in = ST_CP_RD;
            end
         end
         // pivot search down column ci
         ST_PV_RD: begin
            perm_addr = ck_ff[IB-1:0];
            krow_in = perm_rd;
            state_in = ST_PV_CMP;
         end
         ST_PV_CMP: begin
            if (ck_ff == ci_ff || cand > best_ff) begin
               best_in = cand;
               piv_k_in = ck_ff;
               piv_row_in = krow_ff;
               piv_val_in = lu_rdata;
            end
            if (ck_ff == ci_ff) cur_row_in = krow_ff;
            if (ck_ff == n_m1) state_in = ST_SW_A;
            else begin
               ck_in = ck_ff + 1'b1;
               state_in = ST_PV_RD;
            end
         end
         // swap row order entries
         ST_SW_A: begin
            perm_we = 1'b1;
            state_in = ST_SW_B;
         end
         ST_SW_B: begin
            perm_we = 1'b1;
            perm_wa = piv_k_ff[IB-1:0];
            perm_wd = cur_row_ff;
            if (best_ff == '0) begin
               sing_in = 1'b1;
               ci_in = '0;
               state_in = ST_OUT_RD;
            end else if (ci_ff == n_m1) begin
               ci_in = '0;
               state_in = ST_FW_ST;
            end else begin
               cj_in = ci_ff + 1'b1;
               state_in = ST_EL_RD;
            end
         end
         // multiplier for row cj
         ST_EL_RD: begin
            perm_addr = cj_ff[IB-1:0];
            jrow_in = perm_rd;
            state_in = ST_EL_DIV;
         end
         ST_EL_DIV: begin
            div_req.start = 1'b1;
            state_in = ST_EL_DW;
         end
         ST_EL_DW: begin
            lu_wa = {jrow_ff, ci_ff[IB-1:0]};
            lu_wd = div_rsp.value;
            if (div_rsp.done) begin
               lu_we = 1'b1;
               f_in = div_rsp.value;
               ck_in = ci_ff + 1'b1;
               state_in = ST_EU_RB;
            end
         end
         // row update: a[j][k] -= f * a[i][k]
         ST_EU_RB: begin
            lu_ra = {piv_row_ff, ck_ff[IB-1:0]};
            state_in = ST_EU_RC;
         end
         ST_EU_RC: begin
            mul_req.start = 1'b1;
            mul_req.a = f_ff;
            mul_req.b = lu_rdata;
            lu_ra = {jrow_ff, ck_ff[IB-1:0]};
            state_in = ST_EU_MW;
         end
         ST_EU_MW: begin
            lu_ra = {jrow_ff, ck_ff[IB-1:0]};
            lu_wa = {jrow_ff, ck_ff[IB-1:0]};
            lu_wd = lups_pkg::sat_sub(lu_rdata, mul_rsp.value);
            if (mul_rsp.done) begin
               lu_we = 1'b1;
               if (ck_ff == n_m1) begin
                  if (cj_ff == n_m1) begin
                     ci_in = ci_ff + 1'b1;
                     ck_in = ci_ff + 1'b1;
                     state_in = ST_PV_RD;
                  end else begin
                     cj_in = cj_ff + 1'b1;
                     state_in = ST_EL_RD;
                  end
               end else begin
                  ck_in = ck_ff + 1'b1;
                  state_in = ST_EU_RB;
               end
            end
         end
         // forward substitution
         ST_FW_ST: begin
            acc_in = '0;
            cj_in = '0;
            state_in = (ci_ff == '0) ? ST_FW_RHS : ST_FW_RD;
         end
         ST_FW_RD: begin
            lu_ra = {perm_rd, cj_ff[IB-1:0]};
            state_in = ST_FW_MS;
         end
         ST_FW_MS: begin
            mul_req.start = 1'b1;
            state_in = ST_FW_MW;
         end
         ST_FW_MW: begin
            if (mul_rsp.done) begin
               acc_in = lups_pkg::sat_add(acc_ff, mul_rsp.value);
               if (cj_ff + 1'b1 == ci_ff) state_in = ST_FW_RHS;
               else begin
                  cj_in = cj_ff + 1'b1;
                  state_in = ST_FW_RD;
               end
            end
         end
         ST_FW_RHS: state_in = ST_FW_WR;
         ST_FW_WR: begin
            wv_we = 1'b1;
            if (ci_ff == n_m1) state_in = ST_BK_ST;
            else begin
               ci_in = ci_ff + 1'b1;
               state_in = ST_FW_ST;
            end
         end
         // back substitution
         ST_BK_ST: begin
            acc_in = '0;
            cj_in = ci_ff + 1'b1;
            state_in = (ci_ff == n_m1) ? ST_BK_RW : ST_BK_RD;
         end
         ST_BK_RD: begin
            lu_ra = {perm_rd, cj_ff[IB-1:0]};
            state_in = ST_BK_MS;
         end
         ST_BK_MS: begin
            mul_req.start = 1'b1;
            state_in = ST_BK_MW;
         end
         ST_BK_MW: begin
            if (mul_rsp.done) begin
               acc_in = lups_pkg::sat_add(acc_ff, mul_rsp.value);
               if (cj_ff == n_m1) state_in = ST_BK_RW;
               else begin
                  cj_in = cj_ff + 1'b1;
                  state_in = ST_BK_RD;
               end
            end
         end
         ST_BK_RW: begin
            lu_ra = {perm_rd, ci_ff[IB-1:0]};
            wv_ra = ci_ff[IB-1:0];
            state_in = ST_BK_DS;
         end
         ST_BK_DS: begin
            div_req.start = 1'b1;
            div_req.a = lups_pkg::sat_sub(wv_rdata, acc_ff);
            div_req.b = lu_rdata;
            state_in = ST_BK_DW;
         end
         ST_BK_DW: begin
            wv_wd = div_rsp.value;
            if (div_rsp.done) begin
               wv_we = 1'b1;
               if (ci_ff == '0) state_in = ST_OUT_RD;
               else begin
                  ci_in = ci_ff - 1'b1;
                  state_in = ST_BK_ST;
               end
            end
         end
         // emit results
         ST_OUT_RD: begin
            wv_ra = ci_ff[IB-1:0];
            state_in = ST_OUT_EM;
         end
         ST_OUT_EM: begin
            rsp_valid = 1'b1;
            if (ci_ff == n_m1) state_in = ST_IDLE;
            else begin
               ci_in = ci_ff + 1'b1;
               state_in = ST_OUT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_solution_index = ci_ff[IB-1:0];
   assign rsp_solution_value = sing_ff ? lups_pkg::value_type'(0) : wv_rdata;
   assign rsp_last_element = (ci_ff == n_m1);
   assign rsp_singular = sing_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= CB'(lups_pkg::MAX_SIZE);
         sing_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sing_ff <= sing_in;
         if (csr_write_enable) size_ff <= csr_system_size;
      end
      ci_ff <= ci_in;
      cj_ff <= cj_in;
      ck_ff <= ck_in;
      n_ff <= n_in;
      best_ff <= best_in;
      piv_k_ff <= piv_k_in;
      piv_row_ff <= piv_row_in;
      cur_row_ff <= cur_row_in;
      krow_ff <= krow_in;
      jrow_ff <= jrow_in;
      piv_val_ff <= piv_val_in;
      f_ff <= f_in;
      acc_ff <= acc_in;
   end

   // row order table
   always_ff @(posedge clock) begin
      if (reset || perm_init) begin
         for (int r = 0; r < lups_pkg::MAX_SIZE; r++) begin
            perm_ff[r] <= IB'(r);
         end
      end else if (perm_we) begin
         perm_ff[perm_wa] <= perm_wd;
      end
   end

`ifndef SYNTHESIS
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_rsp.done, div_rsp.done})) else $error("both units finished at once");
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> $past(rsp_valid && rsp_last_element))
      else $error("solve ended without last element");
`endif

endmodule
